>>> sv/lis_pkg.sv
// shared types and constants for the longest increasing subsequence unit
`default_nettype none
package lis_pkg;

	localparam int VALUE_W = 32;
	localparam int LEN_W   = 11;

	// one input transfer
	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      last;
	} item_t;

	// one result transfer
	typedef struct packed {
		logic [LEN_W-1:0] lis_length;
		logic             final_res;
		logic             overflow;
	} result_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;         // capture accepted item
		logic first;        // store first value of a sequence
		logic append;       // push value above the top tail
		logic set_ovf;      // append dropped, table full
		logic search_start; // open search window over the table
		logic rd;           // read the midpoint tail
		logic cmp;          // narrow window from the read tail
		logic write_lo;     // replace tail at the window bound
		logic emit;         // load result register
	} lis_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic cnt_zero;
		logic gt_top;
		logic lt_top;
		logic full;
		logic search_end;
		logic out_free;
	} lis_sts_t;

endpackage
`default_nettype wire

>>> sv/lis_ram.sv
// generic single-port ram with registered read
`default_nettype none
module lis_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read on the same address
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule
`default_nettype wire

>>> sv/lis_ctrl.sv
// controller state machine for the longest increasing subsequence unit
`default_nettype none
module lis_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_stall,
	input  wire lis_pkg::lis_sts_t sts,
	output lis_pkg::lis_cmd_t      cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_READ,
		S_CMP,
		S_WRITE,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;

	assign item_stall = (state_q != S_IDLE);

	// next state and datapath commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EVAL;
				end
			end
			S_EVAL: begin
				if (sts.cnt_zero) begin
					cmd.first = 1'b1;
					state_d   = S_DONE;
				end else if (sts.gt_top) begin
					if (sts.full) begin
						cmd.set_ovf = 1'b1;
					end else begin
						cmd.append = 1'b1;
					end
					state_d = S_DONE;
				end else if (sts.lt_top) begin
					cmd.search_start = 1'b1;
					state_d          = S_READ;
				end else begin
					state_d = S_DONE;
				end
			end
			S_READ: begin
				if (sts.search_end) begin
					state_d = S_WRITE;
				end else begin
					cmd.rd  = 1'b1;
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				cmd.cmp = 1'b1;
				state_d = S_READ;
			end
			S_WRITE: begin
				cmd.write_lo = 1'b1;
				state_d      = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

>>> sv/lis_dp.sv
// datapath: tail table, length, search window and result register
`default_nettype none
module lis_dp #(
	parameter int TAILS_DEPTH = 1024
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lis_pkg::item_t    item_data,
	input  wire lis_pkg::lis_cmd_t cmd,
	output lis_pkg::lis_sts_t      sts,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output lis_pkg::result_t       result_data
);

	localparam int CW = $clog2(TAILS_DEPTH + 1);
	localparam int AW = $clog2(TAILS_DEPTH);

	lis_pkg::item_t                     item_q;
	logic signed [lis_pkg::VALUE_W-1:0] top_q;
	logic [CW-1:0]                      count_q;
	logic                               ovf_q;
	logic [CW-1:0]                      lo_q;
	logic [CW-1:0]                      hi_q;
	logic [CW-1:0]                      mid_q;
	logic                               out_valid_q;
	lis_pkg::result_t                   out_q;

	logic [CW:0]                        sum_w;
	logic [CW-1:0]                      mid_w;
	logic                               ram_we;
	logic [AW-1:0]                      ram_addr;
	logic [lis_pkg::VALUE_W-1:0]        ram_rdata;

	// search midpoint
	assign sum_w = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid_w = sum_w[CW:1];

	// tail table port
	assign ram_we = cmd.first | cmd.append | cmd.write_lo;
	always_comb begin
		if (cmd.first) begin
			ram_addr = '0;
		end else if (cmd.append) begin
			ram_addr = count_q[AW-1:0];
		end else if (cmd.write_lo) begin
			ram_addr = lo_q[AW-1:0];
		end else begin
			ram_addr = mid_w[AW-1:0];
		end
	end

	lis_ram #(
		.WIDTH(lis_pkg::VALUE_W),
		.DEPTH(TAILS_DEPTH)
	) u_tails (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(item_q.value),
		.rdata(ram_rdata)
	);

	// status to controller
	assign sts.cnt_zero   = (count_q == '0);
	assign sts.gt_top     = (item_q.value > top_q);
	assign sts.lt_top     = (item_q.value < top_q);
	assign sts.full       = (count_q == CW'(TAILS_DEPTH));
	assign sts.search_end = (lo_q == hi_q);
	assign sts.out_free   = !out_valid_q || !result_stall;

	assign result_valid = out_valid_q;
	assign result_data  = out_q;

	// control state: length, overflow flag, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.first) begin
				count_q <= CW'(1);
			end else if (cmd.append) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.emit && item_q.last) begin
				count_q <= '0;
			end
			if (cmd.set_ovf) begin
				ovf_q <= 1'b1;
			end else if (cmd.emit && item_q.last) begin
				ovf_q <= 1'b0;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item_data;
		end
		if (cmd.first || cmd.append) begin
			top_q <= item_q.value;
		end else if (cmd.write_lo && (lo_q == count_q - CW'(1))) begin
			top_q <= item_q.value;
		end
		if (cmd.search_start) begin
			lo_q <= '0;
			hi_q <= count_q;
		end else if (cmd.cmp) begin
			if ($signed(ram_rdata) < item_q.value) begin
				lo_q <= mid_q + CW'(1);
			end else begin
				hi_q <= mid_q;
			end
		end
		if (cmd.rd) begin
			mid_q <= mid_w;
		end
		if (cmd.emit) begin
			out_q.lis_length <= lis_pkg::LEN_W'(count_q);
			out_q.final_res  <= item_q.last;
			out_q.overflow   <= ovf_q;
		end
	end

endmodule
`default_nettype wire

>>> sv/longest_increasing_subsequence_unit.sv
// top level of the longest increasing subsequence unit
// Takes one signed 32-bit value per transfer and returns one result per value:
// the length of the longest strictly increasing subsequence so far, a copy of
// the last flag and a sticky overflow flag; length and flag clear after the
// last value. A new value is taken only once the previous one has finished;
// the result waits in an output register, so the next value may enter while
// it is still stalled. A value that starts or extends the table, equals the
// top tail or finds the table full needs no search. Any other value runs a
// binary search over the tail memory, each probe split into a read state and
// a compare state because of the registered read. The tail memory needs no
// clearing after reset.
`default_nettype none
module longest_increasing_subsequence_unit #(
	parameter int TAILS_DEPTH = 1024
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_stall,
	input  wire lis_pkg::item_t   item_data,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output lis_pkg::result_t      result_data
);

	lis_pkg::lis_cmd_t cmd;
	lis_pkg::lis_sts_t sts;

	// sequencing
	lis_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// table and arithmetic
	lis_dp #(
		.TAILS_DEPTH(TAILS_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_data   (item_data),
		.cmd         (cmd),
		.sts         (sts),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_data (result_data)
	);

endmodule
`default_nettype wire

>>> sv/lis_chk.sv
// port checker for the longest increasing subsequence unit
`default_nettype none
module lis_chk #(
	parameter int TAILS_DEPTH = 1024
) (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             item_valid,
	input wire logic             item_stall,
	input wire lis_pkg::item_t   item_data,
	input wire logic             result_valid,
	input wire logic             result_stall,
	input wire lis_pkg::result_t result_data
);

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result_data))
		else $error("stalled result changed");

	// one value at a time: busy right after a transfer in
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("second value taken while busy");

	// reported length never exceeds the table size
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (TAILS_DEPTH > 2047) || (result_data.lis_length <= TAILS_DEPTH))
		else $error("length above table size");

	// every result follows at least one value, so length is nonzero
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (TAILS_DEPTH > 2047) || (result_data.lis_length != 0))
		else $error("zero length reported");

endmodule

bind longest_increasing_subsequence_unit lis_chk #(
	.TAILS_DEPTH(TAILS_DEPTH)
) u_lis_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item_valid),
	.item_stall  (item_stall),
	.item_data   (item_data),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.result_data (result_data)
);
`default_nettype wire
